/* hw/rtl/fba_pkg.sv */
package fba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_TEST  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  // set bits of one bitmap word: per-byte sums, then the four bytes
  function automatic logic [5:0] ones_in(input logic [WORD_BITS-1:0] w);
    logic [3:0] byte_cnt [4];
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(w[8*b+k]);
      end
    end
    return 6'(byte_cnt[0]) + 6'(byte_cnt[1]) + 6'(byte_cnt[2]) + 6'(byte_cnt[3]);
  endfunction

  // index of the lowest clear bit; meaningful only when the word is not full
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* hw/rtl/frame_bitmap_allocator_core.sv */
// Channel   Ports                                           Handshake
// request   opcode, frame_number                            start && !busy
// result    frame_out, status, was_set, used_frames         done, one cycle, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata, prdata    APB write, pready tied high
//
// Mark, free and test pass through S_OP to the done cycle; the next word may be
// accepted in that done cycle. Allocate goes through S_SCAN instead, stepping over each
// full bitmap word from the first-free hint; the bitmap memory reads one word a cycle.
// After reset a clearing pass over all BITMAP_FRAMES/32 words (2048 by default) holds busy high.
// A frame_count write holds busy high while the used count is rebuilt from the scanned
// words (frame_count/32, capped at the bitmap size).
// The receiver cannot stall: done marks each result for exactly one cycle.
module frame_bitmap_allocator_core import fba_pkg::*; #(
  parameter int BITMAP_FRAMES = 65536  // power of two, 128 to 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] frame_number,
  output logic        done,
  output logic [15:0] frame_out,
  output logic [1:0]  status,
  output logic        was_set,
  output logic [16:0] used_frames,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NUM_WORDS = BITMAP_FRAMES / WORD_BITS;
  localparam int ADDR_W    = $clog2(NUM_WORDS);
  localparam int FRAME_W   = $clog2(BITMAP_FRAMES);
  localparam int IDX_W     = (FRAME_W < 16) ? FRAME_W : 16;
  localparam int SCAN_W    = ADDR_W + 1;
  localparam int CMP_W     = (SCAN_W > 12) ? SCAN_W : 12;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_SCAN,
    S_COUNT
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [16:0]          frame_count;
  logic                 recount_req;
  logic [SCAN_W-1:0]    cur;
  logic [ADDR_W-1:0]    hint;
  logic [16:0]          used_count;
  logic [16:0]          used_next;
  logic [5:0]           pc;
  logic                 pv;

  opcode_t              req_op;
  logic [15:0]          req_frame;
  logic [ADDR_W-1:0]    req_word;
  logic [BIT_W-1:0]     req_bit;

  logic [IDX_W-1:0]     in_idx;
  logic [ADDR_W-1:0]    in_word;
  logic [CMP_W-1:0]     scan_raw;
  logic [SCAN_W-1:0]    scan_n;
  logic [WORD_BITS-1:0] mask;
  logic                 was;
  logic                 req_counted;
  logic                 cur_in_scan;
  logic                 word_full;
  logic [BIT_W-1:0]     free_bit;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? {15'b0, frame_count} : '0;

  assign busy = (state != S_IDLE) || recount_req;

  // frame index wraps at the bitmap size
  assign in_idx  = frame_number[IDX_W-1:0];
  assign in_word = ADDR_W'(in_idx[IDX_W-1:BIT_W]);

  assign scan_raw = CMP_W'(frame_count[16:5]);
  assign scan_n   = (scan_raw > CMP_W'(NUM_WORDS)) ? SCAN_W'(NUM_WORDS) : SCAN_W'(scan_raw);

  assign mask        = WORD_BITS'(1) << req_bit;
  assign was         = |(rd_data & mask);
  assign req_counted = ({1'b0, req_word} < scan_n);
  assign cur_in_scan = (cur < scan_n);
  assign word_full   = (rd_data == FULL_WORD);
  assign free_bit    = lowest_clear(rd_data);

  always_comb begin
    rd_addr   = ADDR_W'(cur + SCAN_W'(1));
    wr_en     = 1'b0;
    wr_addr   = req_word;
    wr_data   = rd_data | mask;
    used_next = used_count;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cur[ADDR_W-1:0];
        wr_data = '0;
      end
      S_IDLE: begin
        if (recount_req) begin
          rd_addr = '0;
        end else if (opcode_t'(opcode) == OP_ALLOC) begin
          rd_addr = hint;
        end else begin
          rd_addr = in_word;
        end
      end
      S_OP: begin
        case (req_op)
          OP_MARK: begin
            wr_en = 1'b1;
            if (!was && req_counted) begin
              used_next = used_count + 17'd1;
            end
          end
          OP_FREE: begin
            wr_en   = was;
            wr_data = rd_data & ~mask;
            if (was && req_counted) begin
              used_next = used_count - 17'd1;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (cur_in_scan && !word_full) begin
          wr_en     = 1'b1;
          wr_addr   = cur[ADDR_W-1:0];
          wr_data   = rd_data | (WORD_BITS'(1) << free_bit);
          used_next = used_count + 17'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cur         <= '0;
      hint        <= '0;
      used_count  <= '0;
      recount_req <= 1'b0;
      frame_count <= 17'h10000;
      pv          <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          cur <= cur + SCAN_W'(1);
          if (cur[ADDR_W-1:0] == ADDR_W'(NUM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (recount_req) begin
            recount_req <= 1'b0;
            used_count  <= '0;
            cur         <= '0;
            pv          <= 1'b0;
            state       <= S_COUNT;
          end else if (start) begin
            req_op    <= opcode_t'(opcode);
            req_frame <= frame_number;
            req_word  <= in_word;
            req_bit   <= in_idx[BIT_W-1:0];
            if (opcode_t'(opcode) == OP_ALLOC) begin
              cur   <= {1'b0, hint};
              state <= S_SCAN;
            end else begin
              state <= S_OP;
            end
          end
        end
        S_OP: begin
          done        <= 1'b1;
          frame_out   <= req_frame;
          was_set     <= was;
          status      <= (req_op == OP_FREE && !was) ? ST_NOT_ALLOC : ST_OK;
          used_count  <= used_next;
          used_frames <= used_next;
          // a freed word below the hint becomes the first candidate
          if (req_op == OP_FREE && was && req_word < hint) begin
            hint <= req_word;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (!cur_in_scan) begin
            done        <= 1'b1;
            frame_out   <= '0;
            was_set     <= 1'b0;
            status      <= ST_NO_FREE;
            used_frames <= used_count;
            state       <= S_IDLE;
          end else if (!word_full) begin
            done        <= 1'b1;
            frame_out   <= 16'({cur[ADDR_W-1:0], free_bit});
            was_set     <= 1'b0;
            status      <= ST_OK;
            used_count  <= used_next;
            used_frames <= used_next;
            hint        <= cur[ADDR_W-1:0];
            state       <= S_IDLE;
          end else begin
            cur <= cur + SCAN_W'(1);
          end
        end
        S_COUNT: begin
          // pc holds the count of the word that rd_data held in the previous cycle
          used_count <= used_count + (pv ? 17'(pc) : 17'd0);
          pc         <= ones_in(rd_data);
          pv         <= cur_in_scan;
          cur        <= cur + SCAN_W'(1);
          if (!cur_in_scan) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_wr && paddr[2] == 1'b0) begin
        frame_count <= pwdata[16:0];
        recount_req <= 1'b1;
      end
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_no_free_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NO_FREE) |-> (frame_out == 16'd0 && !was_set))
    else $error("failed allocate carries a frame");

  a_op_write_word: assert property (@(posedge clk) disable iff (rst)
    (state == S_OP && wr_en) |-> (wr_addr == req_word))
    else $error("update written to the wrong word");

  a_test_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_OP && req_op == OP_TEST) |-> !wr_en)
    else $error("test changed the bitmap");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || state == S_COUNT) |-> busy)
    else $error("request taken during sweep");

endmodule

/* tb/frame_bitmap_allocator_core_tb.sv */
`timescale 1ns / 1ps

module frame_bitmap_allocator_core_tb;
  import fba_pkg::*;

  localparam int BITMAP_FRAMES = 65536;
  localparam int NUM_WORDS     = BITMAP_FRAMES / WORD_BITS;
  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int NUM_DIR       = 27;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_ITEMS   = 257;

  localparam logic [2:0] ADDR_FRAME_COUNT = 3'd0;
  localparam logic [2:0] ADDR_SPARE       = 3'd4;  // index past the register list

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic [15:0] frame;
    status_t     status;
    logic        was;
    logic [16:0] used;
  } frame_reply_t;

  typedef struct {
    row_kind_t    kind;
    logic [2:0]   addr;
    logic [16:0]  value;
    opcode_t      op;
    logic [15:0]  fn;
    bit           typed;
    frame_reply_t reply;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [15:0] frame_number;
  logic        done;
  logic [15:0] frame_out;
  logic [1:0]  status;
  logic        was_set;
  logic [16:0] used_frames;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_bitmap_allocator_core #(.BITMAP_FRAMES(BITMAP_FRAMES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .frame_number(frame_number),
    .done(done), .frame_out(frame_out), .status(status),
    .was_set(was_set), .used_frames(used_frames),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [WORD_BITS-1:0] shadow_bitmap [NUM_WORDS];
  logic [16:0]          shadow_frame_count;
  logic [16:0]          shadow_used;
  frame_reply_t         frame_replies [$];
  frame_reply_t         head_reply;
  int                   err_count;
  int                   cycle_count;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'h0000, 1'b1, '{16'h0000, ST_OK, 1'b0, 17'd0}},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'hFFFF, 1'b1, '{16'h0000, ST_OK, 1'b0, 17'd1}},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h0000, 1'b1, '{16'h0001, ST_OK, 1'b0, 17'd2}},
    '{ROW_REQ, 3'd0, 17'd0, OP_FREE,  16'h0000, 1'b1, '{16'h0000, ST_OK, 1'b1, 17'd1}},
    '{ROW_REQ, 3'd0, 17'd0, OP_FREE,  16'h0000, 1'b1,
      '{16'h0000, ST_NOT_ALLOC, 1'b0, 17'd1}},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h1234, 1'b1, '{16'h0000, ST_OK, 1'b0, 17'd2}},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'hFFFF, 1'b1, '{16'hFFFF, ST_OK, 1'b0, 17'd3}},
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'hFFFF, 1'b1, '{16'hFFFF, ST_OK, 1'b1, 17'd3}},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'hFFFF, 1'b1, '{16'hFFFF, ST_OK, 1'b1, 17'd3}},
    '{ROW_REQ, 3'd0, 17'd0, OP_FREE,  16'hFFFF, 1'b1, '{16'hFFFF, ST_OK, 1'b1, 17'd2}},
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'hAAAA, 1'b1, '{16'hAAAA, ST_OK, 1'b0, 17'd2}},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'h0002, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'h0005, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h0000, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h5555, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h0000, 1'b0, '0},
    '{ROW_CFG, ADDR_SPARE, 17'h1F0F0, OP_TEST, 16'h0000, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'h5555, 1'b0, '0},
    '{ROW_CFG, ADDR_FRAME_COUNT, 17'd128, OP_TEST, 16'h0000, 1'b0, '0},
    // frames past frame_count still live in the bitmap but are not counted
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'd200, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'd200, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_FREE,  16'd200, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'd127, 1'b0, '0},
    // 1000 frames: the partial last word is neither counted nor allocated
    '{ROW_CFG, ADDR_FRAME_COUNT, 17'd1000, OP_TEST, 16'h0000, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_MARK,  16'd995, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_ALLOC, 16'h0000, 1'b0, '0},
    '{ROW_REQ, 3'd0, 17'd0, OP_TEST,  16'd995, 1'b0, '0}
  };

  logic [16:0] phase_counts [NUM_PHASES] = '{
    17'd256, 17'd65536, 17'd128, 17'd1000, 17'd131071, 17'd4096, 17'd128
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int scanned_words();
    int n;
    n = int'(shadow_frame_count >> 5);
    if (n > NUM_WORDS) n = NUM_WORDS;
    return n;
  endfunction

  function automatic frame_reply_t apply_frame_op(opcode_t op, logic [15:0] fn);
    frame_reply_t r;
    int           n;
    int           total;
    bit           found;
    n       = scanned_words();
    r.frame  = fn;
    r.status = ST_OK;
    r.was    = 1'b0;
    if (op == OP_ALLOC) begin
      r.frame = '0;
      found   = 1'b0;
      for (int i = 0; i < n && !found; i++) begin
        if (shadow_bitmap[i] != FULL_WORD) begin
          for (int j = 0; j < WORD_BITS && !found; j++) begin
            if (!shadow_bitmap[i][j]) begin
              shadow_bitmap[i][j] = 1'b1;
              r.frame = 16'(i * WORD_BITS + j);
              found   = 1'b1;
            end
          end
        end
      end
      if (!found) r.status = ST_NO_FREE;
    end else begin
      r.was = shadow_bitmap[fn[15:5]][fn[4:0]];
      if (op == OP_MARK) begin
        shadow_bitmap[fn[15:5]][fn[4:0]] = 1'b1;
      end else if (op == OP_FREE) begin
        if (r.was) shadow_bitmap[fn[15:5]][fn[4:0]] = 1'b0;
        else       r.status = ST_NOT_ALLOC;
      end
    end
    total = 0;
    for (int i = 0; i < n; i++) total += $countones(shadow_bitmap[i]);
    r.used      = 17'(total);
    shadow_used = r.used;
    return r;
  endfunction

  function automatic logic [15:0] pick_frame();
    int lim;
    int near;
    lim = (shadow_frame_count > 17'd65536) ? 65536 : int'(shadow_frame_count);
    near = int'(shadow_used) + 40;
    if (near > lim) near = lim;
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, lim - 1));
      default: return 16'($urandom_range(0, near - 1));
    endcase
  endfunction

  function automatic opcode_t pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 75) return OP_ALLOC;
      if (r < 85) return OP_MARK;
      if (r < 90) return OP_FREE;
      return OP_TEST;
    end
    if (r < 25) return OP_ALLOC;
    if (r < 35) return OP_MARK;
    if (r < 80) return OP_FREE;
    return OP_TEST;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(opcode_t op, logic [15:0] fn, int gap, bit typed,
                           frame_reply_t typed_reply);
    frame_reply_t pred;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    frame_number <= fn;
    do @(posedge clk); while (busy);
    pred = apply_frame_op(op, fn);
    frame_replies.push_back(typed ? typed_reply : pred);
    @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] addr, logic [16:0] value);
    start <= 1'b0;
    while (frame_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    do @(posedge clk); while (busy);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= {15'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_FRAME_COUNT) shadow_frame_count = value;
    @(negedge clk);
    // read back frame_count; an ignored write must leave it alone
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_FRAME_COUNT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[16:0] !== shadow_frame_count) begin
      $error("frame_count readback: expected %0d, actual %0d",
             shadow_frame_count, prdata[16:0]);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (done) begin
      if (frame_replies.size() == 0) begin
        $error("result word with no request outstanding");
        err_count++;
      end else begin
        head_reply = frame_replies.pop_front();
        if (frame_out !== head_reply.frame) begin
          $error("frame_out: expected %0d, actual %0d", head_reply.frame, frame_out);
          err_count++;
        end
        if (status !== head_reply.status) begin
          $error("status: expected %0d, actual %0d", head_reply.status, status);
          err_count++;
        end
        if (was_set !== head_reply.was) begin
          $error("was_set: expected %0d, actual %0d", head_reply.was, was_set);
          err_count++;
        end
        if (used_frames !== head_reply.used) begin
          $error("used_frames: expected %0d, actual %0d", head_reply.used, used_frames);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int gap;
    err_count          = 0;
    cycle_count        = 0;
    rst                = 1'b1;
    start              = 1'b0;
    opcode             = OP_ALLOC;
    frame_number       = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    shadow_frame_count = 17'd65536;
    shadow_used        = '0;
    for (int i = 0; i < NUM_WORDS; i++) shadow_bitmap[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // hold off until the clearing pass is over
    do @(posedge clk); while (busy);
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_register(dir_rows[k].addr, dir_rows[k].value);
      end else begin
        send_word(dir_rows[k].op, dir_rows[k].fn, $urandom_range(0, 7),
                  dir_rows[k].typed, dir_rows[k].reply);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(ADDR_FRAME_COUNT, phase_counts[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // every third run of 32 words goes back to back
        gap = ((k / 32) % 3 == 2) ? 0 : $urandom_range(0, 7);
        send_word(pick_op(k < (PHASE_ITEMS * 3) / 5), pick_frame(), gap, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (frame_replies.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* frame_bitmap_allocator_core.f */
hw/rtl/fba_pkg.sv
hw/rtl/frame_bitmap_allocator_core.sv
tb/frame_bitmap_allocator_core_tb.sv
